/* design/pcocp_pkg.sv */
// ----------------------------------------------------------------------------
// pcocp_pkg
// Shared constants and types for the play-count cache policy.
// ----------------------------------------------------------------------------
package pcocp_pkg;

   localparam int unsigned DefEntries   = 64;
   localparam int unsigned DefKeyBits   = 32;
   localparam int unsigned DefCountBits = 16;
   localparam int unsigned FuncBits     = 2;
   localparam int unsigned SlotBits     = 6;

   typedef enum logic [1:0] {
      FUNC_FIND    = 2'd0,
      FUNC_INSTALL = 2'd1,
      FUNC_TOUCH   = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_INST_RD,
      ST_T_RD_S,
      ST_T_GOT_S,
      ST_T_GOT_P,
      ST_T_WR_P,
      ST_T_RD_N,
      ST_T_WR_N,
      ST_T_WALK_RD,
      ST_T_WALK_CHK,
      ST_T_LINK_RD,
      ST_T_LINK_WR1,
      ST_T_LINK_WR2,
      ST_T_LINK_WR3,
      ST_T_TAIL_RD,
      ST_T_TAIL_WR,
      ST_RESP
   } state_type;

endpackage

/* design/pcocp_ram.sv */
// ----------------------------------------------------------------------------
// pcocp_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pcocp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/play_count_ordered_cache_policy.sv */
// ----------------------------------------------------------------------------
// play_count_ordered_cache_policy
// LFU replacement with recency tie-break over a linked list held in RAM.
// ----------------------------------------------------------------------------
//  channel  | ports                         | dir | meaning
//  request  | req_valid/ready, func,key,slot| in  | one operation word
//  response | rsp_valid/ready, result_slot, | out | one answer word per request
//           | hit, evicted, done_res        |     |
//
//  One word at a time. Find walks the list from the head. Touch bumps the count
//  and, unless it is the head or its prev count is higher, unlinks it and walks
//  from the head to relink it. Install writes the key, then the valid bit. All
//  are paced by the single port of the link RAM. After reset and after clear,
//  a sweep rewrites the list and counts; no request is taken meanwhile (clear
//  answers after its sweep). The response register holds while rsp_ready is low.
// ----------------------------------------------------------------------------
module play_count_ordered_cache_policy
   import pcocp_pkg::*;
#(
   parameter int unsigned ENTRIES    = DefEntries,
   parameter int unsigned KEY_BITS   = DefKeyBits,
   parameter int unsigned COUNT_BITS = DefCountBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FuncBits-1:0]   req_func,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [SlotBits-1:0]   req_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SlotBits-1:0]   rsp_result_slot,
   output logic                  rsp_hit,
   output logic                  rsp_evicted,
   output logic                  rsp_done_res
);

   localparam int unsigned IB = $clog2(ENTRIES);   // index bits
   localparam int unsigned PB = IB + 1;            // pointer bits, ENTRIES = null
   localparam logic [PB-1:0] NIL = PB'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   // node word: {valid, count, next, prev}
   localparam int unsigned NW = 1 + COUNT_BITS + 2 * PB;

   typedef struct packed {
      logic                  valid;
      logic [COUNT_BITS-1:0] count;
      logic [PB-1:0]         next;
      logic [PB-1:0]         prev;
   } node_type;

   state_type state_ff, state_in;
   logic [FuncBits-1:0]   func_ff, func_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SlotBits-1:0]   slot_ff, slot_in;
   logic [PB-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [PB-1:0]         cur_ff, cur_in;       // walk pointer / sweep index
   logic [PB-1:0]         steps_ff, steps_in;
   logic [PB-1:0]         p_ff, p_in, n_ff, n_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;       // touched entry's new count
   node_type              s_ff, s_in;           // touched entry image
   logic [SlotBits-1:0]   res_slot_ff, res_slot_in;
   logic                  hit_ff, hit_in, ev_ff, ev_in, rsp_valid_ff, rsp_valid_in;

   logic                  n_we, k_we;
   logic [IB-1:0]         n_addr, k_addr;
   node_type              n_wd, n_rd;
   logic [NW-1:0]         n_rd_raw;
   logic [KEY_BITS-1:0]   k_rd;

   pcocp_ram #(.WIDTH(NW), .DEPTH(ENTRIES)) u_node_ram (
      .clock(clock), .wr_en(n_we), .addr(n_addr), .wr_data(n_wd), .rd_data(n_rd_raw)
   );
   pcocp_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(k_we), .addr(k_addr), .wr_data(key_ff), .rd_data(k_rd)
   );
   assign n_rd = node_type'(n_rd_raw);

   function automatic logic [IB-1:0] ix(input logic [PB-1:0] p);
      return p[IB-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         func_ff      <= FUNC_FIND;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         func_ff      <= func_in;
      end
      head_ff <= head_in;  tail_ff <= tail_in;
      key_ff <= key_in;    slot_ff <= slot_in;
      steps_ff <= steps_in; p_ff <= p_in; n_ff <= n_in;
      cnt_ff <= cnt_in;    s_ff <= s_in;
      res_slot_ff <= res_slot_in; hit_ff <= hit_in; ev_ff <= ev_in;
   end

   always_comb begin
      state_in = state_ff;   func_in = func_ff;  key_in = key_ff;  slot_in = slot_ff;
      head_in = head_ff;     tail_in = tail_ff;  cur_in = cur_ff;  steps_in = steps_ff;
      p_in = p_ff;           n_in = n_ff;        cnt_in = cnt_ff;  s_in = s_ff;
      res_slot_in = res_slot_ff; hit_in = hit_ff; ev_in = ev_ff;
      rsp_valid_in = rsp_valid_ff;
      n_we = 1'b0;  n_addr = ix(cur_ff);  n_wd = n_rd;
      k_we = 1'b0;  k_addr = ix(cur_ff);
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_SWEEP: begin
            // rewrite one entry of the reset order per cycle
            n_we = 1'b1;
            n_wd.valid = 1'b0;
            n_wd.count = '0;
            n_wd.next  = cur_ff + PB'(1);
            n_wd.prev  = (cur_ff == '0) ? NIL : cur_ff - PB'(1);
            head_in = '0;
            tail_in = PB'(ENTRIES - 1);
            if (cur_ff == PB'(ENTRIES - 1)) begin
               cur_in = '0;
               if (func_ff == FUNC_CLEAR) begin
                  func_in = FUNC_FIND;
                  res_slot_in = '0; hit_in = 1'b0; ev_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cur_in = cur_ff + PB'(1);
            end
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && req_ready) begin
               func_in = req_func; key_in = req_key; slot_in = req_slot;
               hit_in = 1'b0; ev_in = 1'b0; res_slot_in = req_slot;
               steps_in = '0;
               unique case (func_type'(req_func))
                  FUNC_FIND: begin
                     cur_in = head_ff;
                     res_slot_in = SlotBits'(tail_ff);
                     state_in = ST_FIND_RD;
                  end
                  FUNC_INSTALL: begin
                     cur_in = PB'(req_slot);
                     state_in = (32'(req_slot) < ENTRIES) ? ST_INST_RD : ST_RESP;
                  end
                  FUNC_TOUCH: begin
                     cur_in = PB'(req_slot);
                     state_in = (32'(req_slot) < ENTRIES) ? ST_T_RD_S : ST_RESP;
                  end
                  FUNC_CLEAR: begin
                     cur_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_FIND_RD: begin
            // read node and key of cur
            if (cur_ff >= NIL || steps_ff >= NIL) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (!n_rd.valid) begin
               res_slot_in = SlotBits'(cur_ff);
               state_in = ST_RESP;
            end else if (k_rd == key_ff) begin
               res_slot_in = SlotBits'(cur_ff); hit_in = 1'b1;
               state_in = ST_RESP;
            end else if (n_rd.next >= NIL) begin
               n_we = 1'b1; n_wd.valid = 1'b0; n_wd.count = '0;
               res_slot_in = SlotBits'(cur_ff); ev_in = 1'b1;
               state_in = ST_RESP;
            end else begin
               cur_in = n_rd.next; steps_in = steps_ff + PB'(1);
               state_in = ST_FIND_RD;
            end
         end
         ST_INST_RD: begin
            state_in = ST_T_TAIL_WR;   // reuse: write key then valid
            k_we = 1'b1;
         end
         ST_T_RD_S: begin
            state_in = ST_T_GOT_S;
         end
         ST_T_GOT_S: begin
            s_in = n_rd;
            cnt_in = (n_rd.count < CMAX) ? n_rd.count + COUNT_BITS'(1) : n_rd.count;
            n_we = 1'b1; n_wd.count = cnt_in;
            s_in.count = cnt_in;
            p_in = n_rd.prev; n_in = n_rd.next;
            if (head_ff == cur_ff || n_rd.prev >= NIL) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_T_GOT_P;
            end
         end
         ST_T_GOT_P: begin
            n_addr = ix(p_ff);             // read prev
            state_in = ST_T_WR_P;
         end
         ST_T_WR_P: begin
            n_addr = ix(p_ff);
            if (n_rd.count > cnt_ff) begin
               state_in = ST_RESP;
            end else begin
               n_we = 1'b1; n_wd.next = n_ff;
               if (tail_ff == cur_ff) tail_in = p_ff;
               state_in = (n_ff < NIL) ? ST_T_RD_N : ST_T_WALK_RD;
               cur_in = head_ff;
            end
         end
         ST_T_RD_N: begin
            n_addr = ix(n_ff);
            state_in = ST_T_WR_N;
         end
         ST_T_WR_N: begin
            n_addr = ix(n_ff);
            n_we = 1'b1; n_wd.prev = p_ff;
            state_in = ST_T_WALK_RD;
         end
         ST_T_WALK_RD: begin
            if (cur_ff >= NIL || steps_ff >= NIL) begin
               state_in = (cur_ff >= NIL) ? ST_T_TAIL_RD : ST_T_LINK_RD;
            end else begin
               state_in = ST_T_WALK_CHK;
            end
         end
         ST_T_WALK_CHK: begin
            if (n_rd.count > cnt_ff) begin
               cur_in = n_rd.next; steps_in = steps_ff + PB'(1);
               state_in = ST_T_WALK_RD;
            end else begin
               p_in = n_rd.prev;           // insert before cur
               n_we = 1'b1; n_wd.prev = PB'(slot_ff);
               state_in = ST_T_LINK_WR1;
            end
         end
         ST_T_LINK_RD: begin
            // step bound hit: read cur to learn its prev
            state_in = ST_T_LINK_WR3;
         end
         ST_T_LINK_WR3: begin
            p_in = n_rd.prev;
            n_we = 1'b1; n_wd.prev = PB'(slot_ff);
            state_in = ST_T_LINK_WR1;
         end
         ST_T_LINK_WR1: begin
            n_addr = slot_ff[IB-1:0];
            n_we = 1'b1; n_wd = s_ff; n_wd.prev = p_ff; n_wd.next = cur_ff;
            if (p_ff >= NIL) begin
               head_in = PB'(slot_ff);
               state_in = ST_RESP;
            end else begin
               state_in = ST_T_LINK_WR2;
            end
         end
         ST_T_LINK_WR2: begin
            n_addr = ix(p_ff);
            state_in = ST_T_TAIL_WR;
            func_in = FUNC_CLEAR;          // mark: patch next of p
         end
         ST_T_TAIL_RD: begin
            n_addr = ix(tail_ff);
            p_in = tail_ff;
            state_in = ST_T_TAIL_WR;
         end
         ST_T_TAIL_WR: begin
            if (func_ff == FUNC_INSTALL) begin
               // key written in ST_INST_RD; set valid, keep rest
               if (steps_ff == '0) begin
                  steps_in = PB'(1);
               end else begin
                  n_we = 1'b1; n_wd.valid = 1'b1;
                  state_in = ST_RESP;
               end
            end else if (func_ff == FUNC_CLEAR) begin
               n_addr = ix(p_ff);
               n_we = 1'b1; n_wd.next = PB'(slot_ff);
               func_in = FUNC_TOUCH;
               state_in = ST_RESP;
            end else begin
               // append at tail: old tail.next = s, s = {prev tail, null}
               n_addr = ix(p_ff);
               n_we = 1'b1; n_wd.next = PB'(slot_ff);
               s_in.prev = p_ff; s_in.next = NIL;
               tail_in = PB'(slot_ff);
               state_in = ST_T_LINK_WR2;
               func_in = FUNC_INSTALL;
               steps_in = '0;
               cur_in = NIL;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               if (func_ff == FUNC_CLEAR) func_in = FUNC_FIND;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // tail append finishes by writing s image instead of patching p again
      if (state_ff == ST_T_LINK_WR2 && func_ff == FUNC_INSTALL && cur_ff >= NIL) begin
         n_addr = slot_ff[IB-1:0];
         n_we = 1'b1; n_wd = s_ff;
         func_in = FUNC_TOUCH;
         state_in = ST_RESP;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_slot = res_slot_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_done_res    = 1'b1;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the play-count ordered cache policy. Drives find,
// install, touch and clear words, predicts each answer with its own copy of
// the list and counts, and compares the answers field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
   import pcocp_pkg::*;
();

   localparam int unsigned NSLOT    = 64;
   localparam int unsigned NIL      = NSLOT;
   localparam int unsigned CNT_MAX  = 16'hffff;
   localparam int unsigned IDLE_MAX = 2000;

   typedef struct packed {
      logic [5:0] slot;
      logic       hit;
      logic       evicted;
      logic       done;
   } answer_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] key;
      logic [5:0]  slot;
      logic        typed;   // expected answer given in the row
      answer_type  ans;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [31:0] req_key = '0;
   logic [5:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_result_slot;
   logic        rsp_hit;
   logic        rsp_evicted;
   logic        rsp_done_res;

   // predictor state
   logic [31:0] key_mem [NSLOT];
   logic        valid_mem [NSLOT];
   int unsigned count_mem [NSLOT];
   int unsigned next_mem [NSLOT];
   int unsigned prev_mem [NSLOT];
   int unsigned head, tail;

   answer_type  answer_q [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          stim_done = 1'b0;
   logic [31:0] key_pool [8];

   always #5 clock = ~clock;

   play_count_ordered_cache_policy dut (.*);

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic void restore_list();
      for (int i = 0; i < NSLOT; i++) begin
         valid_mem[i] = 1'b0;
         count_mem[i] = 0;
         next_mem[i]  = i + 1;
         prev_mem[i]  = (i == 0) ? NIL : i - 1;
      end
      head = 0;
      tail = NSLOT - 1;
   endfunction

   function automatic void promote(int unsigned s);
      int unsigned p, n, i, steps;
      if (count_mem[s] < CNT_MAX) count_mem[s]++;
      if (head == s) return;
      p = prev_mem[s];
      n = next_mem[s];
      if (p >= NSLOT) return;
      if (count_mem[p] > count_mem[s]) return;
      // unlink
      next_mem[p] = n;
      if (n < NSLOT) prev_mem[n] = p;
      if (tail == s) tail = p;
      i = head;
      steps = 0;
      while (i < NSLOT && steps < NSLOT && count_mem[i] > count_mem[s]) begin
         i = next_mem[i];
         steps++;
      end
      if (i >= NSLOT) begin
         next_mem[tail] = s;
         prev_mem[s] = tail;
         next_mem[s] = NIL;
         tail = s;
      end else begin
         p = prev_mem[i];
         prev_mem[s] = p;
         next_mem[s] = i;
         prev_mem[i] = s;
         if (p >= NSLOT) head = s;
         else next_mem[p] = s;
      end
   endfunction

   function automatic answer_type cache_answer(func_type f, logic [31:0] k, logic [5:0] s);
      answer_type a;
      int unsigned i, steps;
      a = '{slot: s, hit: 1'b0, evicted: 1'b0, done: 1'b1};
      case (f)
         FUNC_FIND: begin
            i = head;
            steps = 0;
            a.slot = 6'(tail);
            while (i < NSLOT && steps < NSLOT) begin
               if (!valid_mem[i]) begin
                  a.slot = 6'(i);
                  break;
               end
               if (key_mem[i] == k) begin
                  a.slot = 6'(i);
                  a.hit = 1'b1;
                  break;
               end
               if (next_mem[i] >= NSLOT) begin
                  valid_mem[i] = 1'b0;
                  count_mem[i] = 0;
                  a.slot = 6'(i);
                  a.evicted = 1'b1;
                  break;
               end
               i = next_mem[i];
               steps++;
            end
         end
         FUNC_INSTALL: begin
            key_mem[s] = k;
            valid_mem[s] = 1'b1;
         end
         FUNC_TOUCH: promote(s);
         default: begin
            restore_list();
            a.slot = '0;
         end
      endcase
      return a;
   endfunction

   // drive one word: random gap, hold valid until accepted; valid stays up
   // after the accepting edge unless the next word draws a gap
   task automatic send_word(func_type f, logic [31:0] k, logic [5:0] s);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_key   <= k;
      req_slot  <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_checked(func_type f, logic [31:0] k, logic [5:0] s);
      answer_q.push_back(cache_answer(f, k, s));
      send_word(f, k, s);
   endtask

   // receiver: draw a stall per word, compare against the oldest expectation
   initial begin
      answer_type want;
      int         stall;
      stall = $urandom_range(0, 7);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               report("answer with none expected", 32'(rsp_result_slot), 0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_result_slot !== want.slot)
                  report("result_slot", 32'(rsp_result_slot), 32'(want.slot));
               if (rsp_hit !== want.hit) report("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_evicted !== want.evicted)
                  report("evicted", 32'(rsp_evicted), 32'(want.evicted));
               if (rsp_done_res !== want.done)
                  report("done_res", 32'(rsp_done_res), 32'(want.done));
            end
            stall = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) stall = 0;
            rsp_ready <= (stall == 0);
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= (stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: count cycles with no accepted word on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX && !(stim_done && answer_q.size() == 0)) begin
            $display("play_count_ordered_cache_policy: mismatch");
            $finish;
         end
      end
   end

   initial begin
      row_type     rows [$];
      row_type     r;
      answer_type  got;
      func_type    f;
      logic [31:0] k;
      int          pick, wait_cycles;

      for (int i = 0; i < NSLOT; i++) key_mem[i] = '0;
      restore_list();
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hffff_ffff;

      // directed words; typed answers only where obvious
      rows.push_back('{FUNC_FIND, 32'h1234_5678, 6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{FUNC_INSTALL, 32'h0, 6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{FUNC_INSTALL, 32'hffff_ffff, 6'd63, 1'b1,
                       '{6'd63, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{FUNC_FIND, 32'h0, 6'd0, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}});
      rows.push_back('{FUNC_FIND, 32'hffff_ffff, 6'd0, 1'b0, '0});
      rows.push_back('{FUNC_TOUCH, 32'h0, 6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{FUNC_TOUCH, 32'h0, 6'd63, 1'b0, '0});  // tail jumps ahead
      rows.push_back('{FUNC_TOUCH, 32'h0, 6'd63, 1'b0, '0});
      rows.push_back('{FUNC_TOUCH, 32'h0, 6'd5, 1'b0, '0});   // touch on empty entry
      rows.push_back('{FUNC_FIND, 32'hffff_ffff, 6'd0, 1'b0, '0});
      rows.push_back('{FUNC_CLEAR, 32'hdead_beef, 6'd17, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{FUNC_FIND, 32'hffff_ffff, 6'd0, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}});
      for (int i = 0; i < 64; i++) begin
         r = '{FUNC_INSTALL, 32'ha000_0000 + i, i[5:0], 1'b0, '0};
         rows.push_back(r);
      end
      rows.push_back('{FUNC_FIND, 32'h5555_aaaa, 6'd0, 1'b1, '{6'd63, 1'b0, 1'b1, 1'b1}});
      rows.push_back('{FUNC_FIND, 32'ha000_0005, 6'd0, 1'b1, '{6'd5, 1'b1, 1'b0, 1'b1}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[n]) begin
         got = cache_answer(rows[n].func, rows[n].key, rows[n].slot);
         answer_q.push_back(rows[n].typed ? rows[n].ans : got);
         send_word(rows[n].func, rows[n].key, rows[n].slot);
      end

      // back to the reset order before the random part
      send_checked(FUNC_CLEAR, 32'h0, 6'd0);
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);

      // random part: mostly fills, hits and touches over a small key pool
      for (int n = 0; n < 470; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) f = FUNC_FIND;
         else if (pick < 65) f = FUNC_INSTALL;
         else if (pick < 98) f = FUNC_TOUCH;
         else f = FUNC_CLEAR;
         k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
         send_checked(f, k, $urandom_range(0, 3) == 0 ? 6'($urandom()) :
                            6'($urandom_range(0, 7)));
      end
      req_valid <= 1'b0;

      stim_done = 1'b1;
      wait_cycles = 0;
      while (answer_q.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("play_count_ordered_cache_policy: match");
      end else begin
         $display("play_count_ordered_cache_policy: mismatch");
      end
      $finish;
   end

endmodule
